[hdl/bpc_pkg.sv]
// Shared types, constants and codes for the binodal phase classifier.
// Depends on nothing; the other design files but bpc_ram refer to it by scoped names.
package bpc_pkg;

  // Table geometry and value width.
  localparam int unsigned TABLE_DEPTH      = 32;
  localparam int unsigned VALUE_BITS       = 32;
  localparam int unsigned IDX_BITS         = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_BITS         = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned INDEX_FIELD_BITS = 5;
  localparam int unsigned LEN_BITS         = 6;
  localparam int unsigned PROD_BITS        = 2 * VALUE_BITS;
  localparam int unsigned ACC_BITS         = PROD_BITS + 1;
  localparam int unsigned ENTRY_BITS       = 3 * VALUE_BITS;

  // Configuration port geometry.
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned REG_IDX_BITS  = 2;
  localparam int unsigned APB_ADDR_BITS = REG_IDX_BITS + 2;

  typedef logic [VALUE_BITS-1:0] value_t;

  // Item operations.
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // Phase codes.
  localparam logic [1:0] PHASE_LIQUID = 2'd0;
  localparam logic [1:0] PHASE_TWO    = 2'd1;
  localparam logic [1:0] PHASE_GAS    = 2'd2;
  localparam logic [1:0] PHASE_SUPER  = 2'd3;

  // Register indexes.
  localparam logic [REG_IDX_BITS-1:0] REG_CRIT_TEMP     = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_CRIT_PRESSURE = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_CRIT_VOLUME   = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_TABLE_LENGTH  = 2'd3;

  // Command beat.
  typedef struct packed {
    logic                        op;
    logic [INDEX_FIELD_BITS-1:0] entry_index;
    value_t                      entry_pressure;
    value_t                      entry_left_volume;
    value_t                      entry_right_volume;
    value_t                      volume;
    value_t                      pressure;
    value_t                      temperature;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic [1:0] phase;
    logic       low_pressure;
    logic       table_error;
  } res_t;

  // One binodal table row as held in the memory.
  typedef struct packed {
    value_t pressure;
    value_t left_volume;
    value_t right_volume;
  } entry_t;

  // Configuration registers as seen by the sequencer.
  typedef struct packed {
    value_t              crit_temp;
    value_t              crit_pressure;
    value_t              crit_volume;
    logic [LEN_BITS-1:0] table_length;
  } cfg_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctrl_t;

endpackage

[hdl/bpc_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the binodal table.
module bpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bpc_mac.sv]
// Shared multiply-accumulate unit: one multiplier feeding a registered accumulator.
// Depends on bpc_pkg.
module bpc_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpc_pkg::mac_ctrl_t            ctrl_i,
  input  bpc_pkg::value_t               a_i,
  input  bpc_pkg::value_t               b_i,
  output logic [bpc_pkg::ACC_BITS-1:0]  acc_o
);

  logic [bpc_pkg::PROD_BITS-1:0] prod;
  logic [bpc_pkg::ACC_BITS-1:0]  acc_d, acc_q;

  // Product of the two operands, added to the accumulator or loaded fresh.
  always_comb begin
    prod  = a_i * b_i;
    acc_d = (ctrl_i.clr ? '0 : acc_q) + bpc_pkg::ACC_BITS'(prod);
  end

  // The accumulator starts from zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

[hdl/bpc_ctrl.sv]
// Sequencer of the classifier: table scan, interpolation set-up and final compare.
// Depends on bpc_pkg and instantiates bpc_mac.
module bpc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cls_start_i,
  input  bpc_pkg::cmd_t                 cmd_i,
  input  bpc_pkg::cfg_t                 cfg_i,
  output logic [bpc_pkg::IDX_BITS-1:0]  rd_addr_o,
  input  bpc_pkg::entry_t               rd_data_i,
  output logic                          busy_o,
  output logic                          res_valid_o,
  output bpc_pkg::res_t                 res_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_PREP   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_CMP    = 3'd5;

  localparam logic [1:0] STEP_LHS  = 2'd0;
  localparam logic [1:0] STEP_NEAR = 2'd1;
  localparam logic [1:0] STEP_FAR  = 2'd2;

  logic [2:0]                    state_d, state_q;
  logic [1:0]                    step_d, step_q;
  logic [bpc_pkg::CNT_BITS-1:0]  k_d, k_q;
  logic [bpc_pkg::CNT_BITS-1:0]  len_d, len_q;
  logic [bpc_pkg::CNT_BITS-1:0]  m;
  bpc_pkg::value_t               v_d, v_q, p_d, p_q, t_d, t_q;
  bpc_pkg::value_t               d_d, d_q, num_d, num_q, dn_d, dn_q;
  bpc_pkg::value_t               hi_p, lo_p, pe;
  logic                          use_left_d, use_left_q;
  bpc_pkg::entry_t               prev_d, prev_q, cur_d, cur_q;
  logic [bpc_pkg::PROD_BITS-1:0] lhs_d, lhs_q;
  logic [bpc_pkg::ACC_BITS-1:0]  lhs_wide, acc;
  logic                          res_valid_d, res_valid_q;
  bpc_pkg::res_t                 res_d, res_q;
  bpc_pkg::mac_ctrl_t            mac_ctrl;
  bpc_pkg::value_t               mac_a, mac_b;
  logic                          found;

  bpc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // The memory read is registered, so the data in a scan cycle belongs to the
  // row addressed in the cycle before.
  assign m         = k_q - 1'b1;
  assign rd_addr_o = k_q[bpc_pkg::IDX_BITS-1:0];
  assign found     = (m != '0) && (rd_data_i.pressure <= p_q);
  assign hi_p      = prev_q.pressure;
  assign lo_p      = cur_q.pressure;
  assign pe        = (p_q < hi_p) ? p_q : hi_p;
  assign lhs_wide  = bpc_pkg::ACC_BITS'(lhs_q);

  // Next-state and datapath control.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    k_d         = k_q;
    len_d       = len_q;
    v_d         = v_q;
    p_d         = p_q;
    t_d         = t_q;
    d_d         = d_q;
    num_d       = num_q;
    dn_d        = dn_q;
    use_left_d  = use_left_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    lhs_d       = lhs_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mac_ctrl    = '0;
    mac_a       = v_q;
    mac_b       = d_q;

    case (state_q)
      S_IDLE: begin
        if (cls_start_i) begin
          v_d = cmd_i.volume;
          p_d = cmd_i.pressure;
          t_d = cmd_i.temperature;
          // A length beyond the table depth is taken as the depth.
          if (32'(cfg_i.table_length) > 32'(bpc_pkg::TABLE_DEPTH)) begin
            len_d = bpc_pkg::CNT_BITS'(bpc_pkg::TABLE_DEPTH);
          end else begin
            len_d = bpc_pkg::CNT_BITS'(cfg_i.table_length);
          end
          k_d     = '0;
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        use_left_d = v_q < cfg_i.crit_volume;
        k_d        = k_q + 1'b1;
        if (t_q >= cfg_i.crit_temp) begin
          res_valid_d = 1'b1;
          res_d.phase = (p_q >= cfg_i.crit_pressure) ? bpc_pkg::PHASE_SUPER
                                                     : bpc_pkg::PHASE_GAS;
          res_d.low_pressure = 1'b0;
          res_d.table_error  = 1'b0;
          state_d            = S_IDLE;
        end else if (len_q == '0) begin
          res_valid_d        = 1'b1;
          res_d.phase        = bpc_pkg::PHASE_LIQUID;
          res_d.low_pressure = 1'b0;
          res_d.table_error  = 1'b1;
          state_d            = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (found) begin
          cur_d   = rd_data_i;
          state_d = S_PREP;
        end else begin
          prev_d = rd_data_i;
          if (m == len_q - 1'b1) begin
            // Pressure lies below every usable row.
            res_valid_d        = 1'b1;
            res_d.phase        = (v_q <= cfg_i.crit_volume) ? bpc_pkg::PHASE_TWO
                                                            : bpc_pkg::PHASE_GAS;
            res_d.low_pressure = 1'b1;
            res_d.table_error  = 1'b0;
            state_d            = S_IDLE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end

      S_PREP: begin
        // Segment weights; a flat or rising segment takes the lower row alone.
        if (hi_p <= lo_p) begin
          d_d   = bpc_pkg::VALUE_BITS'(1);
          num_d = '0;
          dn_d  = bpc_pkg::VALUE_BITS'(1);
        end else begin
          d_d   = hi_p - lo_p;
          num_d = pe - lo_p;
          dn_d  = hi_p - pe;
        end
        step_d  = STEP_LHS;
        state_d = S_MUL;
      end

      S_MUL: begin
        case (step_q)
          STEP_LHS: begin
            mac_ctrl = '{en: 1'b1, clr: 1'b1};
            mac_a    = v_q;
            mac_b    = d_q;
            step_d   = STEP_NEAR;
          end
          STEP_NEAR: begin
            lhs_d    = acc[bpc_pkg::PROD_BITS-1:0];
            mac_ctrl = '{en: 1'b1, clr: 1'b1};
            mac_a    = use_left_q ? cur_q.left_volume : cur_q.right_volume;
            mac_b    = dn_q;
            step_d   = STEP_FAR;
          end
          STEP_FAR: begin
            mac_ctrl = '{en: 1'b1, clr: 1'b0};
            mac_a    = use_left_q ? prev_q.left_volume : prev_q.right_volume;
            mac_b    = num_q;
            state_d  = S_CMP;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_CMP: begin
        // The accumulator holds the interpolated volume scaled by the segment span.
        res_valid_d        = 1'b1;
        res_d.low_pressure = 1'b0;
        res_d.table_error  = 1'b0;
        if (use_left_q) begin
          res_d.phase = (lhs_wide < acc) ? bpc_pkg::PHASE_LIQUID : bpc_pkg::PHASE_TWO;
        end else begin
          res_d.phase = (lhs_wide > acc) ? bpc_pkg::PHASE_GAS : bpc_pkg::PHASE_TWO;
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_LHS;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    v_q        <= v_d;
    p_q        <= p_d;
    t_q        <= t_d;
    d_q        <= d_d;
    num_q      <= num_d;
    dn_q       <= dn_d;
    use_left_q <= use_left_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    lhs_q      <= lhs_d;
    res_q      <= res_d;
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[hdl/binodal_phase_classifier.sv]
// Top level of the binodal phase classifier: configuration registers, table memory
// and sequencer. Depends on bpc_pkg, bpc_ram and bpc_ctrl.
//
// Use: a command beat is taken at a rising edge with start high and busy low.
// A load beat writes one table row into the memory in that edge and leaves busy
// low, so another beat may follow in the next cycle; it gives no result.
// A classify beat raises busy. At or above the critical temperature, or with an
// empty table, busy lasts one cycle. Otherwise the sequencer scans the table one
// row per cycle through the memory's single registered read port, stopping at
// the first row j >= 1 at or below the pressure, then runs the shared multiplier
// three times and makes one wide compare; when no row qualifies, the result comes
// straight after the scan of the last row. The result beat is on res_o for exactly
// one cycle, marked by res_valid_o, in the cycle in which busy falls; a new
// command may be taken in that cycle. The receiver cannot stall, so results are
// never held. Reset clears the registers and the sequencer; the table memory
// holds nothing defined until rows are loaded. Configuration is to be written
// over the APB port only while the block is idle; the block does not enforce
// it. pready is always high.
module binodal_phase_classifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  bpc_pkg::cmd_t                     cmd_i,
  output logic                              res_valid_o,
  output bpc_pkg::res_t                     res_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpc_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [bpc_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [bpc_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  bpc_pkg::cfg_t                       cfg_q;
  logic [bpc_pkg::REG_IDX_BITS-1:0]    reg_idx;
  logic                                cfg_we;
  logic                                accept;
  logic                                load_we;
  logic                                cls_start;
  logic [bpc_pkg::IDX_BITS-1:0]        rd_addr;
  logic [bpc_pkg::ENTRY_BITS-1:0]      rd_word;
  bpc_pkg::entry_t                     wr_entry;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bpc_pkg::APB_ADDR_BITS-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        bpc_pkg::REG_CRIT_TEMP:     cfg_q.crit_temp     <= bpc_pkg::VALUE_BITS'(pwdata);
        bpc_pkg::REG_CRIT_PRESSURE: cfg_q.crit_pressure <= bpc_pkg::VALUE_BITS'(pwdata);
        bpc_pkg::REG_CRIT_VOLUME:   cfg_q.crit_volume   <= bpc_pkg::VALUE_BITS'(pwdata);
        bpc_pkg::REG_TABLE_LENGTH:  cfg_q.table_length  <= bpc_pkg::LEN_BITS'(pwdata);
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      bpc_pkg::REG_CRIT_TEMP:     prdata = bpc_pkg::APB_DATA_BITS'(cfg_q.crit_temp);
      bpc_pkg::REG_CRIT_PRESSURE: prdata = bpc_pkg::APB_DATA_BITS'(cfg_q.crit_pressure);
      bpc_pkg::REG_CRIT_VOLUME:   prdata = bpc_pkg::APB_DATA_BITS'(cfg_q.crit_volume);
      bpc_pkg::REG_TABLE_LENGTH:  prdata = bpc_pkg::APB_DATA_BITS'(cfg_q.table_length);
      default:                    prdata = '0;
    endcase
  end

  // Command decode; a row index beyond the table is dropped.
  assign accept    = start && !busy;
  assign load_we   = accept && (cmd_i.op == bpc_pkg::OP_LOAD) &&
                     (32'(cmd_i.entry_index) < 32'(bpc_pkg::TABLE_DEPTH));
  assign cls_start = accept && (cmd_i.op == bpc_pkg::OP_CLASSIFY);

  assign wr_entry.pressure     = cmd_i.entry_pressure;
  assign wr_entry.left_volume  = cmd_i.entry_left_volume;
  assign wr_entry.right_volume = cmd_i.entry_right_volume;

  bpc_ram #(
    .WIDTH (bpc_pkg::ENTRY_BITS),
    .DEPTH (bpc_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (bpc_pkg::IDX_BITS'(cmd_i.entry_index)),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_word)
  );

  bpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_start_i (cls_start),
    .cmd_i       (cmd_i),
    .cfg_i       (cfg_q),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (bpc_pkg::entry_t'(rd_word)),
    .busy_o      (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

[hdl/bpc_checker.sv]
// Port-level checks of the binodal phase classifier, bound to the top level.
// Depends on bpc_pkg and on the ports of binodal_phase_classifier.
module bpc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input bpc_pkg::cmd_t cmd_i,
  input logic          res_valid_o,
  input bpc_pkg::res_t res_o
);

  // A classify beat always raises busy in the cycle after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.op == bpc_pkg::OP_CLASSIFY) |=> busy)
    else $error("classify beat did not raise busy");

  // A load beat is finished in the edge that takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.op == bpc_pkg::OP_LOAD) |=> !busy)
    else $error("load beat raised busy");

  // A result beat only follows a busy cycle and comes as busy falls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(busy) && !busy))
    else $error("result beat without a preceding classify");

  // Supercritical and empty-table results carry consistent flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.phase == bpc_pkg::PHASE_SUPER) |->
      (!res_o.low_pressure && !res_o.table_error))
    else $error("supercritical result with a flag set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.table_error) |->
      (res_o.phase == bpc_pkg::PHASE_LIQUID && !res_o.low_pressure))
    else $error("empty-table result with wrong phase or flag");

endmodule

bind binodal_phase_classifier bpc_checker u_bpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cmd_i       (cmd_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

[tb/tb.sv]
// Self-checking testbench for the binodal phase classifier: a directed table of beats, then
// random phases of table loads and classify beats, checked by a phase predictor or the plan.
// Depends on bpc_pkg and binodal_phase_classifier.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam value_t      VMAX          = '1;
  localparam int unsigned SETTLE_CYCLES = 45;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned BEAT_TARGET   = 830;
  localparam int unsigned QUIET_FROM    = 300;
  localparam int unsigned QUIET_TO      = 520;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_e;

  // One row of the directed plan: either a register write or a command beat.
  typedef struct packed {
    row_kind_e                 kind;
    logic [REG_IDX_BITS-1:0]   reg_idx;
    logic [APB_DATA_BITS-1:0]  value;
    cmd_t                      beat;
    logic                      typed;
    res_t                      want;
  } plan_row_t;

  logic                     clk_i;
  logic                     rst_ni  = 1'b0;
  logic                     start   = 1'b0;
  logic                     busy;
  cmd_t                     cmd_q   = '0;
  logic                     res_valid_o;
  res_t                     res_o;
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr   = '0;
  logic [APB_DATA_BITS-1:0] pwdata  = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Predictor state: registers and the binodal table as the block should hold them.
  value_t              crit_t  = '0;
  value_t              crit_p  = '0;
  value_t              crit_v  = '0;
  logic [LEN_BITS-1:0] tab_len = '0;
  bit [31:0]           row_p [TABLE_DEPTH];
  bit [31:0]           row_l [TABLE_DEPTH];
  bit [31:0]           row_r [TABLE_DEPTH];

  res_t        awaited_res [$];
  plan_row_t   plan [$];
  int unsigned beats_sent   = 0;
  int unsigned errors       = 0;
  int unsigned stall_cycles = 0;

  binodal_phase_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_q),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Expected phase and flags of one classify beat, given the current registers and table.
  function automatic res_t classify_state(cmd_t c);
    res_t          r;
    int unsigned   len;
    int unsigned   j;
    logic [31:0]   hi_p, lo_p, pe, d, num, vj, vj1;
    logic [64:0]   lhs, rhs;
    logic          liquid_side;
    r = '0;
    len = (tab_len > TABLE_DEPTH) ? TABLE_DEPTH : tab_len;
    if (c.temperature >= crit_t) begin
      r.phase = (c.pressure >= crit_p) ? PHASE_SUPER : PHASE_GAS;
    end else if (len == 0) begin
      r.table_error = 1'b1;
    end else begin
      // First row from index one whose pressure is at or below the state's.
      j = 1;
      while (j < len && row_p[j] > c.pressure) j++;
      if (j >= len) begin
        r.low_pressure = 1'b1;
        r.phase = (c.volume <= crit_v) ? PHASE_TWO : PHASE_GAS;
      end else begin
        hi_p = row_p[j-1];
        lo_p = row_p[j];
        if (hi_p <= lo_p) begin
          d   = 32'd1;
          num = 32'd0;
        end else begin
          pe  = (c.pressure < hi_p) ? c.pressure : hi_p;
          d   = hi_p - lo_p;
          num = pe - lo_p;
        end
        liquid_side = c.volume < crit_v;
        vj  = liquid_side ? row_l[j]   : row_r[j];
        vj1 = liquid_side ? row_l[j-1] : row_r[j-1];
        // Cross-multiplied interpolation: volume * d against the weighted branch volumes.
        rhs = 65'(vj) * 65'(d - num) + 65'(vj1) * 65'(num);
        lhs = 65'(c.volume) * 65'(d);
        if (liquid_side) r.phase = (lhs < rhs) ? PHASE_LIQUID : PHASE_TWO;
        else             r.phase = (lhs > rhs) ? PHASE_GAS : PHASE_TWO;
      end
    end
    return r;
  endfunction

  // A load beat updates the predicted table.
  function automatic void store_row(cmd_t c);
    row_p[c.entry_index] = c.entry_pressure;
    row_l[c.entry_index] = c.entry_left_volume;
    row_r[c.entry_index] = c.entry_right_volume;
  endfunction

  // Beat builders; fields the operation ignores carry random values.
  function automatic cmd_t load_beat(logic [INDEX_FIELD_BITS-1:0] idx, value_t p, value_t l,
                                     value_t r);
    cmd_t c;
    c.op                 = OP_LOAD;
    c.entry_index        = idx;
    c.entry_pressure     = p;
    c.entry_left_volume  = l;
    c.entry_right_volume = r;
    c.volume             = $urandom;
    c.pressure           = $urandom;
    c.temperature        = $urandom;
    return c;
  endfunction

  function automatic cmd_t state_beat(value_t v, value_t p, value_t t);
    cmd_t c;
    c.op                 = OP_CLASSIFY;
    c.entry_index        = INDEX_FIELD_BITS'($urandom);
    c.entry_pressure     = $urandom;
    c.entry_left_volume  = $urandom;
    c.entry_right_volume = $urandom;
    c.volume             = v;
    c.pressure           = p;
    c.temperature        = t;
    return c;
  endfunction

  function automatic plan_row_t cfg_row(logic [REG_IDX_BITS-1:0] idx,
                                        logic [APB_DATA_BITS-1:0] val);
    plan_row_t row;
    row = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.value   = val;
    return row;
  endfunction

  function automatic plan_row_t beat_row(cmd_t c, logic typed, res_t want);
    plan_row_t row;
    row = '0;
    row.kind  = ROW_BEAT;
    row.beat  = c;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // Register level with the extremes taken now and then.
  function automatic value_t pick_level(value_t lo, value_t hi);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return VMAX;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Offer one command beat, with a random gap first outside the quiet stretch.
  task automatic issue(cmd_t c, logic typed, res_t want);
    if (!(beats_sent >= QUIET_FROM && beats_sent < QUIET_TO) && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_q <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    beats_sent++;
    if (c.op == OP_LOAD) store_row(c);
    else awaited_res.push_back(typed ? want : classify_state(c));
  endtask

  // Wait until every result has arrived and the block has had time to finish.
  task automatic settle();
    start <= 1'b0;
    while (awaited_res.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_register(logic [REG_IDX_BITS-1:0] idx, logic [APB_DATA_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_CRIT_TEMP:     crit_t  = val;
      REG_CRIT_PRESSURE: crit_p  = val;
      REG_CRIT_VOLUME:   crit_v  = val;
      REG_TABLE_LENGTH:  tab_len = val[LEN_BITS-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Fill rows 0..n-1 with descending pressures and branch volumes around Vc.
  // Now and then a row gets random content, which breaks the ordering.
  task automatic load_table(int unsigned n);
    longint unsigned step, pcur;
    value_t          pv, lv, rv;
    step = 64'hFFFF_FFFF / (n + 1);
    pcur = 64'hFFFF_FFFF - $urandom_range(0, 32'(step));
    for (int unsigned i = 0; i < n; i++) begin
      pv = value_t'(pcur);
      if ($urandom_range(0, 15) == 0) pv = $urandom;
      if (i == n - 1 && $urandom_range(0, 3) == 0) pv = '0;
      pcur = pcur - $urandom_range(1, 32'(step));
      if ($urandom_range(0, 7) == 0) begin
        lv = $urandom;
        rv = $urandom;
      end else begin
        lv = $urandom_range(0, crit_v);
        rv = $urandom_range(crit_v, VMAX);
      end
      issue(load_beat(INDEX_FIELD_BITS'(i), pv, lv, rv), 1'b0, '0);
    end
  endtask

  // One random beat: mostly a classify beat aimed at the table's rows, sometimes a reload.
  task automatic random_beat(int unsigned n);
    int unsigned                 k, kp;
    logic [INDEX_FIELD_BITS-1:0] idx;
    value_t                      p, v, t;
    k  = (n > 0) ? $urandom_range(0, n - 1) : 0;
    kp = (k > 0) ? k - 1 : 0;
    if ($urandom_range(0, 9) == 0) begin
      idx = INDEX_FIELD_BITS'($urandom);
      p = $urandom_range(0, 1) ? row_p[idx] : $urandom;
      issue(load_beat(idx, p, $urandom, $urandom), 1'b0, '0);
    end else begin
      if (crit_t != 0 && $urandom_range(0, 4) != 0) t = $urandom_range(0, crit_t - 1);
      else t = $urandom_range(crit_t, VMAX);
      case ($urandom_range(0, 6))
        0:       p = row_p[k];
        1:       p = $urandom_range(row_p[k], row_p[kp]);
        2:       p = '0;
        3:       p = VMAX;
        4:       p = row_p[k] + 1;
        5:       p = row_p[k] - 1;
        default: p = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       v = crit_v;
        1:       v = crit_v - 1;
        2:       v = crit_v + 1;
        3:       v = row_l[k];
        4:       v = row_r[k];
        5:       v = $urandom_range(row_l[k], row_l[kp]);
        6:       v = $urandom_range(row_r[k], row_r[kp]);
        7:       v = '0;
        8:       v = VMAX;
        default: v = $urandom;
      endcase
      issue(state_beat(v, p, t), 1'b0, '0);
    end
  endtask

  // Result monitor: each result beat is compared with the oldest expectation.
  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni && res_valid_o) begin
      if (awaited_res.size() == 0) begin
        $display("%0t: result beat with nothing expected: phase %0d low %0d err %0d", $time,
                 res_o.phase, res_o.low_pressure, res_o.table_error);
        errors++;
      end else begin
        exp_res = awaited_res.pop_front();
        if (res_o.phase !== exp_res.phase) begin
          $display("%0t: phase mismatch: expected %0d, actual %0d", $time, exp_res.phase,
                   res_o.phase);
          errors++;
        end
        if (res_o.low_pressure !== exp_res.low_pressure) begin
          $display("%0t: low_pressure mismatch: expected %0d, actual %0d", $time,
                   exp_res.low_pressure, res_o.low_pressure);
          errors++;
        end
        if (res_o.table_error !== exp_res.table_error) begin
          $display("%0t: table_error mismatch: expected %0d, actual %0d", $time,
                   exp_res.table_error, res_o.table_error);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any beat moving ends the run.
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Stimulus: reset, the directed plan, then random phases.
  initial begin : stimulus
    logic [LEN_BITS-1:0] len_w;
    int unsigned         n;

    // Directed plan. Expected results are written in where they follow at once.
    plan.push_back(beat_row(state_beat('0, '0, '0), 1'b1, {PHASE_SUPER, 1'b0, 1'b0}));
    plan.push_back(beat_row(state_beat(VMAX, VMAX, VMAX), 1'b1, {PHASE_SUPER, 1'b0, 1'b0}));
    plan.push_back(cfg_row(REG_CRIT_TEMP, VMAX));
    plan.push_back(cfg_row(REG_CRIT_PRESSURE, VMAX));
    plan.push_back(beat_row(state_beat('0, VMAX, VMAX), 1'b1, {PHASE_SUPER, 1'b0, 1'b0}));
    plan.push_back(beat_row(state_beat(VMAX, VMAX - 1, VMAX), 1'b1, {PHASE_GAS, 1'b0, 1'b0}));
    // Empty table below the critical temperature.
    plan.push_back(beat_row(state_beat(VMAX, '0, '0), 1'b1, {PHASE_LIQUID, 1'b0, 1'b1}));
    plan.push_back(beat_row(state_beat('0, VMAX, VMAX - 1), 1'b1, {PHASE_LIQUID, 1'b0, 1'b1}));
    plan.push_back(cfg_row(REG_CRIT_VOLUME, 32'h8000_0000));
    plan.push_back(cfg_row(REG_CRIT_TEMP, 32'hC000_0000));
    plan.push_back(cfg_row(REG_CRIT_PRESSURE, 32'h9000_0000));
    plan.push_back(cfg_row(REG_TABLE_LENGTH, 32'd1));
    // A one-row table never gives a segment.
    plan.push_back(beat_row(load_beat(5'd0, VMAX, '0, VMAX), 1'b0, '0));
    plan.push_back(beat_row(state_beat('0, '0, '0), 1'b1, {PHASE_TWO, 1'b1, 1'b0}));
    plan.push_back(beat_row(state_beat(VMAX, VMAX, '0), 1'b1, {PHASE_GAS, 1'b1, 1'b0}));
    plan.push_back(beat_row(state_beat(32'h8000_0000, 32'h1234, 32'hBFFF_FFFF), 1'b1,
                            {PHASE_TWO, 1'b1, 1'b0}));
    plan.push_back(cfg_row(REG_TABLE_LENGTH, 32'd4));
    plan.push_back(beat_row(load_beat(5'd1, 32'hC000_0000, 32'h1000_0000, 32'hF000_0000),
                            1'b0, '0));
    plan.push_back(beat_row(load_beat(5'd2, 32'h8000_0000, 32'h2000_0000, 32'hE000_0000),
                            1'b0, '0));
    plan.push_back(beat_row(load_beat(5'd3, 32'h4000_0000, 32'h3000_0000, 32'hD000_0000),
                            1'b0, '0));
    plan.push_back(beat_row(load_beat(5'd31, '0, VMAX, '0), 1'b0, '0));
    // Pressure below every row.
    plan.push_back(beat_row(state_beat('0, 32'h3FFF_FFFF, '0), 1'b1, {PHASE_TWO, 1'b1, 1'b0}));
    // Pressure above the first row, exact row pressure, both branches.
    plan.push_back(beat_row(state_beat(32'h1000_0000, VMAX, '0), 1'b0, '0));
    plan.push_back(beat_row(state_beat(32'h2000_0000, 32'h8000_0000, '0), 1'b0, '0));
    plan.push_back(beat_row(state_beat(32'h1FFF_FFFF, 32'h8000_0000, '0), 1'b0, '0));
    plan.push_back(beat_row(state_beat(32'h8000_0000, 32'h6000_0000, '0), 1'b0, '0));
    plan.push_back(beat_row(state_beat(VMAX, 32'hA000_0000, '0), 1'b0, '0));
    plan.push_back(beat_row(state_beat(32'h7FFF_FFFF, 32'h5000_0000, '0), 1'b0, '0));
    // First segment made degenerate: row 0 below row 1.
    plan.push_back(beat_row(load_beat(5'd0, 32'h3000_0000, 32'h5000_0000, 32'hB000_0000),
                            1'b0, '0));
    plan.push_back(beat_row(state_beat(32'h4000_0000, 32'hD000_0000, '0), 1'b0, '0));
    plan.push_back(beat_row(state_beat(32'hF000_0000, 32'hC000_0000, '0), 1'b0, '0));

    // Hold reset, then release it.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_register(plan[i].reg_idx, plan[i].value);
      end else begin
        issue(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: new registers, a fresh table, then a run of mostly classify beats.
    while (beats_sent < BEAT_TARGET) begin
      settle();
      case ($urandom_range(0, 19))
        0:       len_w = '0;
        1:       len_w = LEN_BITS'(TABLE_DEPTH);
        2:       len_w = LEN_BITS'($urandom_range(TABLE_DEPTH + 1, 63));
        3:       len_w = LEN_BITS'(1);
        4, 5, 6: len_w = LEN_BITS'($urandom_range(9, TABLE_DEPTH - 1));
        default: len_w = LEN_BITS'($urandom_range(2, 8));
      endcase
      write_register(REG_CRIT_TEMP, pick_level(32'h1000_0000, 32'hF000_0000));
      write_register(REG_CRIT_PRESSURE, pick_level('0, VMAX));
      write_register(REG_CRIT_VOLUME, pick_level(32'h2000_0000, 32'hE000_0000));
      write_register(REG_TABLE_LENGTH, 32'(len_w));
      n = (tab_len > TABLE_DEPTH) ? TABLE_DEPTH : tab_len;
      load_table(n);
      repeat ($urandom_range(15, 40)) random_beat(n);
    end

    settle();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/bpc_pkg.sv
hdl/bpc_ram.sv
hdl/bpc_mac.sv
hdl/bpc_ctrl.sv
hdl/binodal_phase_classifier.sv
hdl/bpc_checker.sv
tb/tb.sv
